// ===== src/bba_pkg.sv =====
// types and constants shared by the block bitmap allocator
// no dependencies
package bba_pkg;

    localparam int OP_W       = 2;
    localparam int BLK_W      = 14;
    localparam int ST_W       = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_FORMAT = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_COUNT = 1'd1;

    localparam logic [CFG_DATA_W-1:0] BLOCK_COUNT_RST    = 15'd16384;
    localparam logic [CFG_DATA_W-1:0] RESERVED_COUNT_RST = 15'd0;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [BLK_W-1:0] target_block;
    } t_in_item;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [BLK_W-1:0] granted_block;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clr_write;
        logic scan_issue;
        logic alloc_commit;
        logic free_advance;
        logic free_read;
        logic free_write;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic issue_ok;
        logic last_word;
        logic ev_valid;
        logic ev_hit;
        logic free_hit;
        logic range_err;
    } t_dp_stat;

endpackage

// ===== src/block_bitmap_allocator_top.sv =====
// first-fit block bitmap allocator: config registers, result register, assertions
// depends on bba_pkg, bba_ctrl, bba_datapath
//
// channel   direction  handshake              beat
// in        input      i_in_valid/o_in_stall  t_in_item (operation, target_block)
// out       output     o_out_valid/i_out_stall t_out_item (status, granted_block)
// cfg       input      i_cfg_valid/o_cfg_ready index + 15-bit data
//
// one item at a time: a new beat is taken only after the result is loaded
// allocate: scans map words in order below the block count; full when none holds a free bit
// free: steps to the word of target_block, then reads and rewrites it; out of range answers without a map access
// format: one word written per cycle
// after reset a clearing pass writes every map word with in stalled
// a finished request waits while the result register holds a stalled beat
module block_bitmap_allocator_top
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS    = 16384,
    parameter int MAP_WORD_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_item              i_in_item,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_item,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CFG_DATA_W-1:0] r_block_count;
    logic [CFG_DATA_W-1:0] r_reserved_count;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic             out_free;
    logic             out_load;
    logic [ST_W-1:0]  status;
    logic [BLK_W-1:0] granted;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count    <= BLOCK_COUNT_RST;
            r_reserved_count <= RESERVED_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BLOCK_COUNT:    r_block_count    <= i_cfg_data;
                CFG_RESERVED_COUNT: r_reserved_count <= i_cfg_data;
            endcase
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item.status        <= status;
            r_out_item.granted_block <= (status == ST_OK) ? granted : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_in_item.operation),
        .o_in_stall  (o_in_stall),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .i_out_free  (out_free),
        .o_out_load  (out_load),
        .o_status    (status)
    );

    bba_datapath #(
        .MAX_BLOCKS    (MAX_BLOCKS),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_target         (i_in_item.target_block),
        .i_block_count    (r_block_count),
        .i_reserved_count (r_reserved_count),
        .o_granted        (granted)
    );

    // the clearing pass keeps in stalled right after reset
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> o_in_stall)
        else $error("input taken during clearing pass");

    // an accepted beat always starts work
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // only a successful allocate carries a block number
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != ST_OK) |-> (o_out_item.granted_block == '0))
        else $error("granted block on failed request");

    // a result is loaded only when the register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result register overwritten");

endmodule

// ===== src/bba_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/bba_datapath.sv =====
// map storage, word/base counters, free-bit search and read-modify-write
// depends on bba_pkg and bba_ram
module bba_datapath
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS    = 16384,
    parameter int MAP_WORD_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic [BLK_W-1:0]      i_target,
    input  logic [CFG_DATA_W-1:0] i_block_count,
    input  logic [CFG_DATA_W-1:0] i_reserved_count,
    output logic [BLK_W-1:0]      o_granted
);

    localparam int WB    = MAP_WORD_BITS;
    localparam int DEPTH = (MAX_BLOCKS + WB - 1) / WB;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TOTAL = DEPTH * WB;
    localparam int TW    = $clog2(TOTAL + 1);
    localparam int CW    = (TW > CFG_DATA_W) ? TW : CFG_DATA_W;
    localparam int BW    = $clog2(WB);
    localparam int RW    = $clog2(WB + 1);

    // bits of the word at base that lie below cnt
    function automatic logic [WB-1:0] below_mask(input logic [CW-1:0] cnt,
                                                 input logic [CW-1:0] base);
        logic [CW-1:0] rem;
        logic [RW-1:0] rc;
        logic [WB-1:0] m;
        rem = (cnt > base) ? (cnt - base) : '0;
        rc  = (rem >= CW'(WB)) ? RW'(WB) : rem[RW-1:0];
        for (int i = 0; i < WB; i++) begin
            m[i] = (RW'(i) < rc);
        end
        return m;
    endfunction

    logic [CW-1:0] bc_ext;
    logic [CW-1:0] res_ext;
    logic [CW-1:0] eff_count;
    logic [CW-1:0] fill_count;

    logic [AW-1:0] r_word;
    logic [CW-1:0] r_base;
    logic          r_ev_valid;
    logic [CW-1:0] r_fill;
    logic [AW-1:0] r_ev_word;
    logic [CW-1:0] r_ev_base;
    logic [CW-1:0] r_target;
    logic [BLK_W-1:0] r_grant;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [WB-1:0] wr_data;
    logic          rd_en;
    logic [WB-1:0] rd_data;

    logic [WB-1:0] freebits;
    logic [BW-1:0] hit_idx;
    logic [CW-1:0] grant_sum;
    logic [CW-1:0] bit_diff;
    logic [CW:0]   base_end;

    assign bc_ext     = CW'(i_block_count);
    assign res_ext    = CW'(i_reserved_count);
    assign eff_count  = (bc_ext > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : bc_ext;
    assign fill_count = (res_ext < eff_count) ? res_ext : eff_count;

    assign freebits = ~rd_data & below_mask(eff_count, r_ev_base);

    // lowest free bit
    always_comb begin
        hit_idx = '0;
        for (int i = WB - 1; i >= 0; i--) begin
            if (freebits[i]) begin
                hit_idx = BW'(i);
            end
        end
    end

    assign grant_sum = r_ev_base + CW'(hit_idx);
    assign bit_diff  = r_target - r_ev_base;
    assign base_end  = {1'b0, r_base} + (CW + 1)'(WB);

    assign o_stat.issue_ok  = (r_base < eff_count);
    assign o_stat.last_word = (r_word == AW'(DEPTH - 1));
    assign o_stat.ev_valid  = r_ev_valid;
    assign o_stat.ev_hit    = |freebits;
    assign o_stat.free_hit  = ({1'b0, r_target} < base_end);
    assign o_stat.range_err = (r_target >= eff_count);

    assign rd_en = (i_cmd.scan_issue && o_stat.issue_ok) || i_cmd.free_read;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_ev_word;
        wr_data = rd_data;
        if (i_cmd.clr_write) begin
            wr_en   = 1'b1;
            wr_addr = r_word;
            wr_data = below_mask(r_fill, r_base);
        end else if (i_cmd.alloc_commit) begin
            wr_en   = 1'b1;
            wr_data = rd_data | (WB'(1) << hit_idx);
        end else if (i_cmd.free_write) begin
            wr_en   = 1'b1;
            wr_data = rd_data & ~(WB'(1) << bit_diff[BW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word     <= '0;
            r_base     <= '0;
            r_ev_valid <= 1'b0;
            r_fill     <= '0;
        end else begin
            if (i_cmd.load) begin
                r_word     <= '0;
                r_base     <= '0;
                r_ev_valid <= 1'b0;
                r_fill     <= fill_count;
            end else if (i_cmd.clr_write || i_cmd.free_advance) begin
                r_word <= r_word + AW'(1);
                r_base <= r_base + CW'(WB);
            end else if (i_cmd.scan_issue) begin
                if (o_stat.issue_ok) begin
                    r_ev_valid <= 1'b1;
                    r_word     <= r_word + AW'(1);
                    r_base     <= r_base + CW'(WB);
                end else begin
                    r_ev_valid <= 1'b0;
                end
            end else if (i_cmd.alloc_commit) begin
                r_ev_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_target <= CW'(i_target);
            r_grant  <= '0;
        end
        if ((i_cmd.scan_issue && o_stat.issue_ok) || i_cmd.free_read) begin
            r_ev_word <= r_word;
            r_ev_base <= r_base;
        end
        if (i_cmd.alloc_commit) begin
            r_grant <= grant_sum[BLK_W-1:0];
        end
    end

    assign o_granted = r_grant;

    bba_ram #(
        .WIDTH (WB),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_word),
        .o_rd_data (rd_data)
    );

endmodule

// ===== src/bba_ctrl.sv =====
// sequencer for allocate, free, format and the clearing pass after reset
// depends on bba_pkg
module bba_ctrl
    import bba_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [OP_W-1:0] i_operation,
    output logic            o_in_stall,
    input  t_dp_stat        i_stat,
    output t_dp_cmd         o_cmd,
    input  logic            i_out_free,
    output logic            o_out_load,
    output logic [ST_W-1:0] o_status
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ASCAN,
        S_FSCAN,
        S_FMOD,
        S_DONE
    } t_state;

    t_state          r_state, n_state;
    logic            r_respond, n_respond;
    logic [ST_W-1:0] r_status, n_status;

    always_comb begin
        n_state    = r_state;
        n_respond  = r_respond;
        n_status   = r_status;
        o_cmd      = '0;
        o_out_load = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                if (i_stat.last_word) begin
                    n_state = r_respond ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_status   = ST_OK;
                    n_respond  = 1'b1;
                    case (i_operation)
                        OP_ALLOC:  n_state = S_ASCAN;
                        OP_FREE:   n_state = S_FSCAN;
                        OP_FORMAT: n_state = S_CLEAR;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_ASCAN: begin
                if (i_stat.ev_valid && i_stat.ev_hit) begin
                    o_cmd.alloc_commit = 1'b1;
                    n_state            = S_DONE;
                end else begin
                    o_cmd.scan_issue = 1'b1;
                    // nothing in flight and nothing left below the count
                    if (!i_stat.ev_valid && !i_stat.issue_ok) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end
                end
            end
            S_FSCAN: begin
                if (i_stat.range_err) begin
                    n_status = ST_RANGE;
                    n_state  = S_DONE;
                end else if (i_stat.free_hit) begin
                    o_cmd.free_read = 1'b1;
                    n_state         = S_FMOD;
                end else begin
                    o_cmd.free_advance = 1'b1;
                end
            end
            S_FMOD: begin
                o_cmd.free_write = 1'b1;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_respond <= 1'b0;
            r_status  <= ST_OK;
        end else begin
            r_state   <= n_state;
            r_respond <= n_respond;
            r_status  <= n_status;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_status   = r_status;

endmodule
